// File: design/pat2d_pkg.sv
// Package for the 2D point transform: widths, codes, trig table and helpers.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package pat2d_pkg;

  // Field widths
  localparam int COORD_BITS     = 16;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_BITS      = 16;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int TRIG_BITS      = TRIG_FRAC_BITS + 2;
  localparam int ANGLE_BITS     = 16;

  // Config port
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 3;

  // Angle handling
  localparam int FULL_TURN      = 360;
  localparam int HALF_TURN      = 180;
  localparam int QUARTER_TURN   = 90;
  localparam int THREE_QUARTER  = 270;
  localparam int ANGLE_RED_BITS = 9;
  localparam int SIN_IDX_BITS   = 7;
  localparam int SIN_MAG_BITS   = TRIG_FRAC_BITS + 1;

  // Datapath widths
  localparam int OPA_W  = COORD_BITS + 1;
  localparam int OPB_W  = GAIN_BITS + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [GAIN_BITS-1:0]  gain_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic [ANGLE_RED_BITS-1:0]    angle_t;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PASS      = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE      = 3'd0,
    REG_SHIFT_X   = 3'd1,
    REG_SHIFT_Y   = 3'd2,
    REG_CENTER_X  = 3'd3,
    REG_CENTER_Y  = 3'd4,
    REG_GAIN_X    = 3'd5,
    REG_GAIN_Y    = 3'd6,
    REG_ANGLE_DEG = 3'd7
  } reg_idx_t;

  typedef struct packed {
    coord_t v;
    logic   clip;
  } sat_t;

  localparam gain_t GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC_BITS);
  localparam trig_t TRIG_ONE = TRIG_BITS'(1 << TRIG_FRAC_BITS);

  // Quarter-wave sine, Q1.14, one entry per degree 0..90
  localparam logic [SIN_MAG_BITS-1:0] SIN_TABLE [0:QUARTER_TURN] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of a reduced angle (0..359) by quadrant folding
  function automatic trig_t sin_deg(input angle_t a);
    angle_t                  idx;
    logic                    neg;
    logic [SIN_MAG_BITS-1:0] mag;
    trig_t                   pos;
    priority if (a <= angle_t'(QUARTER_TURN)) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= angle_t'(HALF_TURN)) begin
      idx = angle_t'(HALF_TURN) - a;
      neg = 1'b0;
    end else if (a <= angle_t'(THREE_QUARTER)) begin
      idx = a - angle_t'(HALF_TURN);
      neg = 1'b1;
    end else begin
      idx = angle_t'(FULL_TURN) - a;
      neg = 1'b1;
    end
    mag = SIN_TABLE[idx[SIN_IDX_BITS-1:0]];
    pos = signed'({1'b0, mag});
    return neg ? -pos : pos;
  endfunction

endpackage

`default_nettype wire

// File: design/pat2d_if.sv
// Valid/ready channel interfaces for point items in and transformed items out.
// Depends on pat2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pat2d_in_if;
  logic              valid;
  logic              ready;
  pat2d_pkg::coord_t point_x;
  pat2d_pkg::coord_t point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface pat2d_out_if;
  logic              valid;
  logic              ready;
  pat2d_pkg::coord_t new_x;
  pat2d_pkg::coord_t new_y;
  logic              clipped;

  modport source (output valid, output new_x, output new_y, output clipped, input ready);
  modport sink   (input valid, input new_x, input new_y, input clipped, output ready);
endinterface

`default_nettype wire

// File: design/point_affine_transform_2d.sv
// Top level of the 2D point transform: translate, scale about a center or
// rotate about a center. Depends on pat2d_pkg and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

// One point item in, one transformed point item out. The block is a four-stage
// pipeline (input register, operand select, multipliers, sum/round/saturate
// into the output register) and takes one item every cycle unless stalled.
// Each stage holds its own valid bit and has its own ready, so bubbles are
// squeezed out and a new item is still taken while a finished result waits
// on a stalled output. Scaling uses signed Q8.8 gains: x' = (g*x + (1-g)*c)
// / 256. Rotation uses Q1.14 sine and cosine from a quarter-wave degree table:
// x' = cx + dx*cos + dy*sin, y' = cy - dx*sin + dy*cos. Results truncate
// toward zero and saturate to 16 bits; clipped flags either axis saturating.
// Mode 3 passes the point through. The angle is reduced mod 360 as it is
// written, and sine/cosine are registered from the reduced angle; write
// configuration only while idle.
module point_affine_transform_2d (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pat2d_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [pat2d_pkg::CFG_BITS-1:0]     cfg_data,
  pat2d_in_if.sink                          in_pt,
  pat2d_out_if.source                       out_pt
);
  import pat2d_pkg::*;

  // Angle reduction constants: bias to a non-negative value, then divide
  // by 360 with a reciprocal multiply.
  localparam int ANGLE_U_BITS = ANGLE_BITS + 1;
  localparam int ANGLE_BIAS   =
    ((2**(ANGLE_BITS-1) + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
  localparam int RECIP_SHIFT  = 25;
  localparam int RECIP        = (2**RECIP_SHIFT + FULL_TURN - 1) / FULL_TURN;
  localparam int RECIP_BITS   = 17;
  localparam int RPROD_BITS   = ANGLE_U_BITS + RECIP_BITS;
  localparam int Q_BITS       = RPROD_BITS - RECIP_SHIFT;
  localparam int COS_SUM_BITS = ANGLE_RED_BITS + 1;

  localparam logic signed [SUM_W-1:0] COORD_HI  = SUM_W'((2**(COORD_BITS-1)) - 1);
  localparam logic signed [SUM_W-1:0] COORD_LO  = -COORD_HI - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] GAIN_RND  = SUM_W'((2**GAIN_FRAC_BITS) - 1);
  localparam logic signed [SUM_W-1:0] TRIG_RND  = SUM_W'((2**TRIG_FRAC_BITS) - 1);

  // angle mod 360, result 0..359
  function automatic angle_t reduce_angle(input logic signed [ANGLE_BITS-1:0] a);
    logic [ANGLE_U_BITS-1:0] u;
    logic [RPROD_BITS-1:0]   prod;
    logic [Q_BITS-1:0]       q;
    logic [ANGLE_U_BITS-1:0] qm;
    u    = ANGLE_U_BITS'(a) + ANGLE_U_BITS'(ANGLE_BIAS);
    prod = RPROD_BITS'(u) * RPROD_BITS'(RECIP);
    q    = prod[RECIP_SHIFT +: Q_BITS];
    qm   = ANGLE_U_BITS'(q) * ANGLE_U_BITS'(FULL_TURN);
    return angle_t'(u - qm);
  endfunction

  // Truncating divide by 2^F per mode, then clamp to coordinate range
  function automatic sat_t round_sat(input logic signed [SUM_W-1:0] s, input mode_t m);
    logic signed [SUM_W-1:0] q;
    sat_t                    r;
    unique case (m)
      MODE_SCALE:  q = (s < 0) ? ((s + GAIN_RND) >>> GAIN_FRAC_BITS) : (s >>> GAIN_FRAC_BITS);
      MODE_ROTATE: q = (s < 0) ? ((s + TRIG_RND) >>> TRIG_FRAC_BITS) : (s >>> TRIG_FRAC_BITS);
      default:     q = s;
    endcase
    if (q > COORD_HI) begin
      r.v    = COORD_HI[COORD_BITS-1:0];
      r.clip = 1'b1;
    end else if (q < COORD_LO) begin
      r.v    = COORD_LO[COORD_BITS-1:0];
      r.clip = 1'b1;
    end else begin
      r.v    = q[COORD_BITS-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  mode_t  mode_r;
  coord_t shift_x_r, shift_y_r, center_x_r, center_y_r;
  gain_t  gain_x_r, gain_y_r;
  angle_t angle_red_r;
  trig_t  sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_TRANSLATE;
      shift_x_r   <= '0;
      shift_y_r   <= '0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      gain_x_r    <= GAIN_ONE;
      gain_y_r    <= GAIN_ONE;
      angle_red_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_MODE:      mode_r      <= mode_t'(cfg_data[1:0]);
        REG_SHIFT_X:   shift_x_r   <= coord_t'(cfg_data);
        REG_SHIFT_Y:   shift_y_r   <= coord_t'(cfg_data);
        REG_CENTER_X:  center_x_r  <= coord_t'(cfg_data);
        REG_CENTER_Y:  center_y_r  <= coord_t'(cfg_data);
        REG_GAIN_X:    gain_x_r    <= gain_t'(cfg_data);
        REG_GAIN_Y:    gain_y_r    <= gain_t'(cfg_data);
        REG_ANGLE_DEG: angle_red_r <= reduce_angle(ANGLE_BITS'(cfg_data));
      endcase
    end
  end

  // cos(a) = sin(a + 90), wrapped
  logic [COS_SUM_BITS-1:0] cos_sum;
  angle_t                  cos_angle;

  always_comb begin
    cos_sum   = COS_SUM_BITS'(angle_red_r) + COS_SUM_BITS'(QUARTER_TURN);
    cos_angle = (cos_sum >= COS_SUM_BITS'(FULL_TURN)) ?
                angle_t'(cos_sum - COS_SUM_BITS'(FULL_TURN)) : angle_t'(cos_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_r <= '0;
      cos_r <= TRIG_ONE;
    end else begin
      sin_r <= sin_deg(angle_red_r);
      cos_r <= sin_deg(cos_angle);
    end
  end

  // ---------------------------------------------------------- flow control
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_r || out_pt.ready;
  assign rdy3        = !v3_r || rdy4;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_pt.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pt.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // -------------------------------------------------- stage 1: input item
  coord_t x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_pt.valid) begin
      x1_r <= in_pt.point_x;
      y1_r <= in_pt.point_y;
    end
  end

  // --------------------------------------------- stage 2: operand select
  logic signed [OPA_W-1:0] xe, ye, cxe, cye, dx, dy;
  logic signed [OPA_W-1:0] ax0_nxt, ax1_nxt, ay0_nxt, ay1_nxt;
  logic signed [OPB_W-1:0] bx0_nxt, bx1_nxt, by0_nxt, by1_nxt;
  logic signed [SUM_W-1:0] basex_nxt, basey_nxt;

  logic signed [OPA_W-1:0] ax0_r, ax1_r, ay0_r, ay1_r;
  logic signed [OPB_W-1:0] bx0_r, bx1_r, by0_r, by1_r;
  logic signed [SUM_W-1:0] basex2_r, basey2_r;
  mode_t                   mode2_r;

  always_comb begin
    xe  = OPA_W'(x1_r);
    ye  = OPA_W'(y1_r);
    cxe = OPA_W'(center_x_r);
    cye = OPA_W'(center_y_r);
    dx  = xe - cxe;
    dy  = ye - cye;

    ax0_nxt   = '0;
    ax1_nxt   = '0;
    ay0_nxt   = '0;
    ay1_nxt   = '0;
    bx0_nxt   = '0;
    bx1_nxt   = '0;
    by0_nxt   = '0;
    by1_nxt   = '0;
    basex_nxt = SUM_W'(x1_r);
    basey_nxt = SUM_W'(y1_r);

    unique case (mode_r)
      MODE_TRANSLATE: begin
        basex_nxt = SUM_W'(x1_r) + SUM_W'(shift_x_r);
        basey_nxt = SUM_W'(y1_r) + SUM_W'(shift_y_r);
      end
      MODE_SCALE: begin
        // g*p + (1-g)*c
        basex_nxt = '0;
        basey_nxt = '0;
        ax0_nxt   = xe;
        bx0_nxt   = OPB_W'(gain_x_r);
        ax1_nxt   = cxe;
        bx1_nxt   = OPB_W'(GAIN_ONE) - OPB_W'(gain_x_r);
        ay0_nxt   = ye;
        by0_nxt   = OPB_W'(gain_y_r);
        ay1_nxt   = cye;
        by1_nxt   = OPB_W'(GAIN_ONE) - OPB_W'(gain_y_r);
      end
      MODE_ROTATE: begin
        basex_nxt = SUM_W'(center_x_r) <<< TRIG_FRAC_BITS;
        basey_nxt = SUM_W'(center_y_r) <<< TRIG_FRAC_BITS;
        ax0_nxt   = dx;
        bx0_nxt   = OPB_W'(cos_r);
        ax1_nxt   = dy;
        bx1_nxt   = OPB_W'(sin_r);
        ay0_nxt   = dx;
        by0_nxt   = -OPB_W'(sin_r);
        ay1_nxt   = dy;
        by1_nxt   = OPB_W'(cos_r);
      end
      MODE_PASS: begin
        basex_nxt = SUM_W'(x1_r);
        basey_nxt = SUM_W'(y1_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      ax0_r    <= ax0_nxt;
      ax1_r    <= ax1_nxt;
      ay0_r    <= ay0_nxt;
      ay1_r    <= ay1_nxt;
      bx0_r    <= bx0_nxt;
      bx1_r    <= bx1_nxt;
      by0_r    <= by0_nxt;
      by1_r    <= by1_nxt;
      basex2_r <= basex_nxt;
      basey2_r <= basey_nxt;
      mode2_r  <= mode_r;
    end
  end

  // -------------------------------------------------- stage 3: multiply
  logic signed [PROD_W-1:0] px0_r, px1_r, py0_r, py1_r;
  logic signed [SUM_W-1:0]  basex3_r, basey3_r;
  mode_t                    mode3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      px0_r    <= PROD_W'(ax0_r) * PROD_W'(bx0_r);
      px1_r    <= PROD_W'(ax1_r) * PROD_W'(bx1_r);
      py0_r    <= PROD_W'(ay0_r) * PROD_W'(by0_r);
      py1_r    <= PROD_W'(ay1_r) * PROD_W'(by1_r);
      basex3_r <= basex2_r;
      basey3_r <= basey2_r;
      mode3_r  <= mode2_r;
    end
  end

  // ---------------------------------- stage 4: sum, round, saturate, out
  logic signed [SUM_W-1:0] sumx, sumy;
  sat_t                    rx, ry;

  always_comb begin
    sumx = basex3_r + SUM_W'(px0_r) + SUM_W'(px1_r);
    sumy = basey3_r + SUM_W'(py0_r) + SUM_W'(py1_r);
    rx   = round_sat(sumx, mode3_r);
    ry   = round_sat(sumy, mode3_r);
  end

  coord_t new_x_r, new_y_r;
  logic   clipped_r;

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      new_x_r   <= rx.v;
      new_y_r   <= ry.v;
      clipped_r <= rx.clip || ry.clip;
    end
  end

  assign out_pt.valid   = v4_r;
  assign out_pt.new_x   = new_x_r;
  assign out_pt.new_y   = new_y_r;
  assign out_pt.clipped = clipped_r;

endmodule

`default_nettype wire

// File: verif/point_affine_transform_2d_test.sv
// Self-checking testbench for point_affine_transform_2d: directed and random point items
// through the valid/ready channels, checked against an in-bench transform predictor.
// Depends on pat2d_pkg, the pat2d channel interfaces and the point_affine_transform_2d RTL.
`timescale 1ns / 1ps

module point_affine_transform_2d_test;
  import pat2d_pkg::*;

  // Watchdog against a run that hangs
  localparam int CYCLE_LIMIT   = 200000;
  // Pipeline depth is four; drain a little past it
  localparam int DRAIN_CYCLES  = 8;
  localparam int DEFAULT_IDLE  = 18;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_POINTS  = 50;
  localparam int BURST_POINTS  = 150;

  typedef logic signed [ANGLE_BITS-1:0] angle_deg_t;

  typedef struct {
    coord_t nx;
    coord_t ny;
    logic   clip;
  } point_result_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CFG_BITS-1:0]     cfg_data;

  pat2d_in_if  in_pt ();
  pat2d_out_if out_pt ();

  point_affine_transform_2d u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_pt    (in_pt),
    .out_pt   (out_pt)
  );

  // Bench copy of the register file, reset values to start
  mode_t      mode_r     = MODE_TRANSLATE;
  coord_t     shift_x_r  = '0;
  coord_t     shift_y_r  = '0;
  coord_t     center_x_r = '0;
  coord_t     center_y_r = '0;
  gain_t      gain_x_r   = GAIN_ONE;
  gain_t      gain_y_r   = GAIN_ONE;
  angle_deg_t angle_r    = '0;

  point_result_t transformed_q[$];
  int            error_count  = 0;
  int            result_count = 0;
  int            cycle_count  = 0;
  int            in_idle_pct  = DEFAULT_IDLE;
  int            out_idle_pct = DEFAULT_IDLE;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q1.14 sine of a reduced angle 0..359, folded onto one quarter wave
  function automatic longint sine_q14(longint a);
    real    deg2rad;
    longint d;
    longint sgn;
    deg2rad = 4.0 * $atan(1.0) / 180.0;
    sgn = 1;
    if (a <= 90) d = a;
    else if (a <= 180) d = 180 - a;
    else if (a <= 270) begin
      d = a - 180;
      sgn = -1;
    end else begin
      d = 360 - a;
      sgn = -1;
    end
    // real-to-integer cast rounds to nearest
    return sgn * longint'(16384.0 * $sin(real'(d) * deg2rad));
  endfunction

  function automatic coord_t clamp_coord(longint v, inout logic clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return coord_t'(hi);
    end
    if (v < lo) begin
      clip = 1'b1;
      return coord_t'(lo);
    end
    return coord_t'(v);
  endfunction

  function automatic point_result_t transform_point(coord_t x, coord_t y);
    point_result_t r;
    longint px, py, cx, cy, rx, ry;
    longint gx, gy, g_one, t_one;
    longint a, s, c, dx, dy;
    px = x;
    py = y;
    cx = center_x_r;
    cy = center_y_r;
    rx = px;
    ry = py;
    g_one = longint'(1) <<< GAIN_FRAC_BITS;
    t_one = longint'(1) <<< TRIG_FRAC_BITS;
    case (mode_r)
      MODE_TRANSLATE: begin
        rx = px + longint'(shift_x_r);
        ry = py + longint'(shift_y_r);
      end
      MODE_SCALE: begin
        gx = gain_x_r;
        gy = gain_y_r;
        // exact sum, then a single truncating divide
        rx = (gx * px + (g_one - gx) * cx) / g_one;
        ry = (gy * py + (g_one - gy) * cy) / g_one;
      end
      MODE_ROTATE: begin
        a = longint'(angle_r) % 360;
        if (a < 0) a += 360;
        s = sine_q14(a);
        c = sine_q14((a + 90) % 360);
        dx = px - cx;
        dy = py - cy;
        rx = (cx * t_one + dx * c + dy * s) / t_one;
        ry = (cy * t_one - dx * s + dy * c) / t_one;
      end
      default: ;  // pass mode: point goes through untouched
    endcase
    r.clip = 1'b0;
    r.nx = clamp_coord(rx, r.clip);
    r.ny = clamp_coord(ry, r.clip);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    $display("MISMATCH result %0d: %s", result_count, what);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    point_result_t want;
    if (rst_n && out_pt.valid === 1'b1 && out_pt.ready === 1'b1) begin
      if (transformed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item x=%0d y=%0d clipped=%0b",
                                  out_pt.new_x, out_pt.new_y, out_pt.clipped));
      end else begin
        want = transformed_q.pop_front();
        if (out_pt.new_x !== want.nx)
          report_mismatch($sformatf("new_x %0d, want %0d", out_pt.new_x, want.nx));
        if (out_pt.new_y !== want.ny)
          report_mismatch($sformatf("new_y %0d, want %0d", out_pt.new_y, want.ny));
        if (out_pt.clipped !== want.clip)
          report_mismatch($sformatf("clipped %0b, want %0b", out_pt.clipped, want.clip));
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("point_affine_transform_2d regression: fail");
      $finish;
    end
  end

  // Output back-pressure, updated on the falling edge
  initial begin
    out_pt.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_pt.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (all called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  // valid is only lowered for a gap, so back-to-back items keep it high
  task automatic send_point(coord_t x, coord_t y);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(negedge clk);
    end
    in_pt.valid   <= 1'b1;
    in_pt.point_x <= x;
    in_pt.point_y <= y;
    do @(posedge clk); while (in_pt.ready !== 1'b1);
    transformed_q.insert(transformed_q.size(), transform_point(x, y));
    @(negedge clk);
  endtask

  // Config only moves while nothing is in flight
  task automatic wait_idle();
    in_pt.valid <= 1'b0;
    @(negedge clk);
    while (transformed_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Leaves cfg_we high so consecutive writes don't toggle it; close with end_cfg
  task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    case (idx)
      REG_MODE:      mode_r     = mode_t'(data[1:0]);
      REG_SHIFT_X:   shift_x_r  = data;
      REG_SHIFT_Y:   shift_y_r  = data;
      REG_CENTER_X:  center_x_r = data;
      REG_CENTER_Y:  center_y_r = data;
      REG_GAIN_X:    gain_x_r   = data;
      REG_GAIN_Y:    gain_y_r   = data;
      REG_ANGLE_DEG: angle_r    = data;
      default: ;
    endcase
  endtask

  // sin/cos are registered from the reduced angle; let them settle after an angle write
  task automatic end_cfg();
    cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  task automatic write_mode(mode_t m);
    write_reg(REG_MODE, {(CFG_BITS - 2)'($urandom), m});
  endtask

  // ---------------------------------------------------------------------------
  // Random value pickers
  // ---------------------------------------------------------------------------

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: return coord_t'(16'h7FFF);
      1: return coord_t'(16'h8000);
      2: return coord_t'(int'($urandom_range(0, 600)) - 300);
      3: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 7))
      0: return gain_t'(16'h7FFF);
      1: return gain_t'(16'h8000);
      2: return '0;
      3, 4: return gain_t'(int'($urandom_range(0, 1024)) - 512 + 256);
      default: return gain_t'($urandom);
    endcase
  endfunction

  function automatic angle_deg_t pick_angle();
    case ($urandom_range(0, 5))
      0: return angle_deg_t'(int'($urandom_range(0, 8)) * 90 - 360);
      1: return angle_deg_t'(int'($urandom_range(0, 180)) * 360 - 32400);
      2: return angle_deg_t'(int'($urandom_range(0, 1440)) - 720);
      default: return angle_deg_t'($urandom);
    endcase
  endfunction

  // Mostly full-range points, some pinned to the edges or close to the center
  task automatic send_random_point();
    coord_t x;
    coord_t y;
    case ($urandom_range(0, 9))
      0: begin
        x = $urandom_range(0, 1) ? coord_t'(16'h7FFF) : coord_t'(16'h8000);
        y = $urandom_range(0, 1) ? coord_t'(16'h7FFF) : coord_t'(16'h8000);
      end
      1, 2: begin
        x = center_x_r + coord_t'(int'($urandom_range(0, 64)) - 32);
        y = center_y_r + coord_t'(int'($urandom_range(0, 64)) - 32);
      end
      default: begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
      end
    endcase
    send_point(x, y);
  endtask

  // New settings for every register, then a run of points under them
  task automatic random_phase(int n_points);
    wait_idle();
    write_mode(mode_t'($urandom_range(0, 3)));
    write_reg(REG_SHIFT_X,   pick_coord());
    write_reg(REG_SHIFT_Y,   pick_coord());
    write_reg(REG_CENTER_X,  pick_coord());
    write_reg(REG_CENTER_Y,  pick_coord());
    write_reg(REG_GAIN_X,    pick_gain());
    write_reg(REG_GAIN_Y,    pick_gain());
    write_reg(REG_ANGLE_DEG, pick_angle());
    end_cfg();
    repeat (n_points) send_random_point();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: translate by zero, i.e. identity
  task automatic test_reset_defaults();
    send_point(coord_t'(16'h7FFF), coord_t'(16'h8000));
    send_point(coord_t'(-5), coord_t'(1234));
  endtask

  // Saturation high and low, on one axis or both
  task automatic test_translate();
    wait_idle();
    write_mode(MODE_TRANSLATE);
    write_reg(REG_SHIFT_X, 16'h7FFF);
    write_reg(REG_SHIFT_Y, 16'h8000);
    end_cfg();
    send_point(coord_t'(16'h7FFF), coord_t'(16'h8000));
    send_point(coord_t'(16'h8000), coord_t'(16'h7FFF));
    wait_idle();
    write_reg(REG_SHIFT_X, 16'h0001);
    write_reg(REG_SHIFT_Y, 16'hFFFF);
    end_cfg();
    send_point(coord_t'(16'h7FFF), coord_t'(0));
    send_point(coord_t'(0), coord_t'(16'h8000));
  endtask

  // Zero gain returns the center; extreme and negative gains
  task automatic test_scale();
    wait_idle();
    write_mode(MODE_SCALE);
    write_reg(REG_CENTER_X, 16'd100);
    write_reg(REG_CENTER_Y, 16'hFFCE);
    write_reg(REG_GAIN_X, 16'h0000);
    write_reg(REG_GAIN_Y, 16'h8000);
    end_cfg();
    send_point(coord_t'(16'h8000), coord_t'(16'h7FFF));
    send_point(coord_t'(3), coord_t'(-49));
    wait_idle();
    write_reg(REG_GAIN_X, 16'h7FFF);
    write_reg(REG_GAIN_Y, 16'hFF00);
    end_cfg();
    send_point(coord_t'(101), coord_t'(7));
    send_point(coord_t'(-3), coord_t'(200));
    send_point(coord_t'(16'h7FFF), coord_t'(16'h8000));
  endtask

  task automatic rotate_one(angle_deg_t ang, coord_t x, coord_t y);
    wait_idle();
    write_reg(REG_ANGLE_DEG, ang);
    end_cfg();
    send_point(x, y);
  endtask

  // Quadrant angles, full turns, negative angles and the angle field extremes
  task automatic test_rotate();
    wait_idle();
    write_mode(MODE_ROTATE);
    write_reg(REG_CENTER_X, 16'h0000);
    write_reg(REG_CENTER_Y, 16'h0000);
    end_cfg();
    rotate_one(angle_deg_t'(90),  coord_t'(1000), coord_t'(2000));
    rotate_one(angle_deg_t'(-90), coord_t'(1000), coord_t'(2000));
    rotate_one(angle_deg_t'(270), coord_t'(-777), coord_t'(31));
    rotate_one(angle_deg_t'(720), coord_t'(16'h7FFF), coord_t'(16'h8000));
    rotate_one(angle_deg_t'(45),  coord_t'(16'h7FFF), coord_t'(16'h7FFF));
    rotate_one(angle_deg_t'(16'h8000), coord_t'(12345), coord_t'(-321));
    rotate_one(angle_deg_t'(16'h7FFF), coord_t'(-12345), coord_t'(321));
    // far center, half turn: both axes run off the range
    wait_idle();
    write_reg(REG_CENTER_X, 16'h7FFF);
    write_reg(REG_CENTER_Y, 16'h8000);
    end_cfg();
    rotate_one(angle_deg_t'(180), coord_t'(16'h8000), coord_t'(16'h7FFF));
  endtask

  // Pass mode (3) passes the point through, upper data bits set too
  task automatic test_pass_through();
    wait_idle();
    write_reg(REG_MODE, 16'hFFFF);
    end_cfg();
    send_point(coord_t'(16'h8000), coord_t'(16'h7FFF));
    send_point(coord_t'(-1), coord_t'(0));
  endtask

  task automatic test_random_settings();
    repeat (RANDOM_PHASES) random_phase(PHASE_POINTS);
  endtask

  // Long stretch with no gaps and no stalls on either side
  task automatic test_burst();
    wait_idle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_phase(BURST_POINTS);
    in_idle_pct  = DEFAULT_IDLE;
    out_idle_pct = DEFAULT_IDLE;
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_MODE;
    cfg_data      <= '0;
    in_pt.valid   <= 1'b0;
    in_pt.point_x <= '0;
    in_pt.point_y <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_translate();
    test_scale();
    test_rotate();
    test_pass_through();
    test_random_settings();
    test_burst();

    in_pt.valid <= 1'b0;
    while (transformed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("point_affine_transform_2d regression: pass");
    end else begin
      $display("point_affine_transform_2d regression: fail");
    end
    $finish;
  end

endmodule
